/* hw/rtl/exact_rational_alu_assert.svh */
// Assertion macros shared by the exact rational ALU RTL.
// Included by the modules that carry concurrent checks.
`ifndef EXACT_RATIONAL_ALU_ASSERT_SVH
`define EXACT_RATIONAL_ALU_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ERA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ERA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hw/rtl/era_pkg.sv */
// Package for the exact rational ALU: operation and status codes.
// No dependencies.
`default_nettype none
package era_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Command to the shared unit.
  typedef struct packed {
    logic start;
    logic is_mul;
  } unit_cmd_t;
endpackage
`default_nettype wire

/* hw/rtl/exact_rational_alu.sv */
// Top level of the exact rational ALU: stream ports and operation sequencer.
// Depends on era_pkg, era_unit and exact_rational_alu_assert.svh.
//
// One beat in, one beat out. Each item runs through a sequencer that drives a
// single shared bit-serial multiply/divide unit. Multiply and divide take two
// unit uses; add and subtract with unequal denominators take three products
// plus a Euclidean GCD where each remainder step is one unit use, then two
// reducing divides when the GCD exceeds one; equal denominators skip the
// products. The special cases (zero operands, except zero minus a nonzero b)
// skip the unit. The input is not ready while an item is in flight; the result
// sits in an output register, so the next beat can be taken while a finished
// result waits downstream.
`default_nettype none
`include "exact_rational_alu_assert.svh"
module exact_rational_alu #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  wire logic [127:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: res_num[63:0], res_den[127:64], status[129:128], zero fill up
  output logic [135:0]      m_axis_tdata
);
  localparam int W = OPERAND_WIDTH;
  localparam logic [3:0] S_IDLE = 4'd0, S_P1 = 4'd1, S_P2 = 4'd2, S_P3 = 4'd3,
                         S_ADD = 4'd4, S_GCD = 4'd5, S_RD1 = 4'd6,
                         S_RD2 = 4'd7, S_OUT = 4'd8, S_MD2 = 4'd9;

  logic [3:0]  st_q, st_d;
  logic [1:0]  op_q, op_d;
  logic        an_q, an_d, bn_q, bn_d, neg_q, neg_d;
  logic [63:0] am_q, am_d, bm_q, bm_d, ad_q, ad_d, bd_q, bd_d;
  logic [63:0] t1_q, t1_d, t2_q, t2_d, gx_q, gx_d, gy_q, gy_d;
  logic [63:0] mag_q, mag_d, den_q, den_d;
  logic        ov_q, ov_d, wait_q, wait_d;
  logic [135:0] out_q, out_d;
  logic [135:0] tdata_q, tdata_d;
  logic        ov_valid_q, ov_valid_d;
  era_pkg::unit_cmd_t cmd;
  logic [63:0] ux, uy, up, ur;
  logic        ubusy;

  era_unit u_unit (.clk_i, .rst_ni, .cmd_i(cmd), .x_i(ux), .y_i(uy),
                   .busy_o(ubusy), .p_o(up), .r_o(ur));

  // split a W-bit numerator field into sign and magnitude
  function automatic logic [64:0] split(input logic [31:0] raw);
    logic [W-1:0] x;
    logic [W-1:0] m;
    x = raw[W-1:0];
    m = x[W-1] ? (~x + 1'b1) : x;
    return {x[W-1], {(64-W){1'b0}}, m};
  endfunction

  function automatic logic [63:0] twos(input logic n, input logic [63:0] m);
    return n ? (~m + 64'd1) : m;
  endfunction

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ov_valid_q;
  assign m_axis_tdata  = tdata_q;

  logic [64:0] sa, sb;
  logic [64:0] sum;
  logic        sneg;
  logic [63:0] smag;

  always_comb begin
    st_d = st_q; op_d = op_q; an_d = an_q; bn_d = bn_q; neg_d = neg_q;
    am_d = am_q; bm_d = bm_q; ad_d = ad_q; bd_d = bd_q;
    t1_d = t1_q; t2_d = t2_q; gx_d = gx_q; gy_d = gy_q;
    mag_d = mag_q; den_d = den_q; ov_d = ov_q;
    // stays set from the start cycle until the unit drops busy
    wait_d = wait_q && ubusy;
    out_d = out_q;
    tdata_d = tdata_q;
    ov_valid_d = ov_valid_q && !m_axis_tready;
    cmd = '0; ux = '0; uy = '0;
    sa = '0; sb = '0; sum = '0; sneg = 1'b0; smag = '0;

    unique case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          sa = split(s_axis_tdata[31:0]);
          sb = split(s_axis_tdata[95:64]);
          op_d = s_axis_tuser;
          an_d = sa[64]; am_d = sa[63:0];
          bn_d = sb[64] ^ (s_axis_tuser == era_pkg::OP_SUB);
          bm_d = sb[63:0];
          ad_d = {{(64-W){1'b0}}, s_axis_tdata[32+W-1:32]};
          bd_d = {{(64-W){1'b0}}, s_axis_tdata[96+W-1:96]};
          // default: a unchanged
          out_d = {6'd0, era_pkg::ST_OK,
                   {{(64-W){1'b0}}, s_axis_tdata[32+W-1:32]},
                   twos(sa[64], sa[63:0])};
          st_d = S_OUT;
          if (s_axis_tuser == era_pkg::OP_ADD && sa[63:0] == '0) begin
            out_d[63:0] = twos(sb[64], sb[63:0]);
            out_d[127:64] = {{(64-W){1'b0}}, s_axis_tdata[96+W-1:96]};
          end else if (sa[63:0] == '0) begin
            if (s_axis_tuser == era_pkg::OP_SUB && sb[63:0] != '0) st_d = S_P1;
          end else if (sb[63:0] == '0) begin
            if (s_axis_tuser == era_pkg::OP_MUL) out_d[63:0] = '0;
            if (s_axis_tuser == era_pkg::OP_DIV)
              out_d = {6'd0, era_pkg::ST_DIV0, 128'd0};
          end else begin
            st_d = S_P1;
          end
          if (st_d == S_P1 && (s_axis_tuser == era_pkg::OP_ADD ||
              s_axis_tuser == era_pkg::OP_SUB) &&
              s_axis_tdata[32+W-1:32] == s_axis_tdata[96+W-1:96]) begin
            t1_d = sa[63:0]; t2_d = sb[63:0];
            den_d = {{(64-W){1'b0}}, s_axis_tdata[32+W-1:32]};
            st_d = S_ADD;
          end
        end
      end
      S_P1: begin // first product
        if (!wait_q && !ubusy) begin
          cmd.start = 1'b1; cmd.is_mul = 1'b1;
          ux = am_q;
          uy = (op_q == era_pkg::OP_MUL) ? bm_q : bd_q;
          wait_d = 1'b1;
        end else if (wait_q && !ubusy) begin
          t1_d = up;
          st_d = (op_q == era_pkg::OP_MUL || op_q == era_pkg::OP_DIV) ? S_MD2 : S_P2;
        end
      end
      S_MD2: begin // second product of multiply/divide
        if (!wait_q && !ubusy) begin
          cmd.start = 1'b1; cmd.is_mul = 1'b1;
          ux = ad_q;
          uy = (op_q == era_pkg::OP_MUL) ? bd_q : bm_q;
          wait_d = 1'b1;
        end else if (wait_q && !ubusy) begin
          out_d = {6'd0, era_pkg::ST_OK, up, twos(an_q ^ bn_q, t1_q)};
          st_d = S_OUT;
        end
      end
      S_P2: begin
        if (!wait_q && !ubusy) begin
          cmd.start = 1'b1; cmd.is_mul = 1'b1;
          ux = bm_q; uy = ad_q; wait_d = 1'b1;
        end else if (wait_q && !ubusy) begin
          t2_d = up; st_d = S_P3;
        end
      end
      S_P3: begin
        if (!wait_q && !ubusy) begin
          cmd.start = 1'b1; cmd.is_mul = 1'b1;
          ux = ad_q; uy = bd_q; wait_d = 1'b1;
        end else if (wait_q && !ubusy) begin
          den_d = up; st_d = S_ADD;
        end
      end
      S_ADD: begin
        ov_d = 1'b0;
        if (an_q == bn_q) begin
          sum = {1'b0, t1_q} + {1'b0, t2_q};
          smag = sum[63:0]; sneg = an_q; ov_d = sum[64];
        end else if (t1_q >= t2_q) begin
          smag = t1_q - t2_q; sneg = an_q;
        end else begin
          smag = t2_q - t1_q; sneg = bn_q;
        end
        if (smag == '0) sneg = 1'b0;
        if ((sneg && smag > 64'h8000000000000000) ||
            (!sneg && smag[63])) ov_d = 1'b1;
        if (ov_d) begin
          out_d = {6'd0, era_pkg::ST_OVF, 128'd0};
          st_d = S_OUT;
        end else begin
          mag_d = smag; neg_d = sneg;
          gx_d = smag; gy_d = den_q; st_d = S_GCD;
        end
      end
      S_GCD: begin
        if (gy_q == '0) begin
          if (gx_q > 64'd1) st_d = S_RD1;
          else begin
            out_d = {6'd0, era_pkg::ST_OK, den_q, twos(neg_q, mag_q)};
            st_d = S_OUT;
          end
        end else if (!wait_q && !ubusy) begin
          cmd.start = 1'b1; ux = gx_q; uy = gy_q; wait_d = 1'b1;
        end else if (wait_q && !ubusy) begin
          gx_d = gy_q; gy_d = ur;
        end
      end
      S_RD1: begin
        if (!wait_q && !ubusy) begin
          cmd.start = 1'b1; ux = mag_q; uy = gx_q; wait_d = 1'b1;
        end else if (wait_q && !ubusy) begin
          mag_d = up; st_d = S_RD2;
        end
      end
      S_RD2: begin
        if (!wait_q && !ubusy) begin
          cmd.start = 1'b1; ux = den_q; uy = gx_q; wait_d = 1'b1;
        end else if (wait_q && !ubusy) begin
          out_d = {6'd0, era_pkg::ST_OK, up, twos(neg_q, mag_q)};
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        // move into the output register once it is free or draining
        if (!ov_valid_q || m_axis_tready) begin
          tdata_d = out_q;
          ov_valid_d = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_valid_q <= 1'b0; wait_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_valid_q <= ov_valid_d; wait_q <= wait_d;
    end
  end
  always_ff @(posedge clk_i) begin
    op_q <= op_d; an_q <= an_d; bn_q <= bn_d; neg_q <= neg_d;
    am_q <= am_d; bm_q <= bm_d; ad_q <= ad_d; bd_q <= bd_d;
    t1_q <= t1_d; t2_q <= t2_d; gx_q <= gx_d; gy_q <= gy_d;
    mag_q <= mag_d; den_q <= den_d; ov_q <= ov_d; out_q <= out_d;
    tdata_q <= tdata_d;
  end

  `ERA_ASSERT_IMP(a_rdy_idle, clk_i, rst_ni, s_axis_tready, st_q == S_IDLE, "ready outside idle")
  `ERA_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
  `ERA_ASSERT_IMP(a_start_free, clk_i, rst_ni, cmd.start, !ubusy, "unit started while busy")
endmodule
`default_nettype wire

/* hw/rtl/era_unit.sv */
// Shared iterative unit: 64x64 shift-add multiply or 64-bit restoring divide.
// One bit per cycle. Depends on era_pkg.
`default_nettype none
module era_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire era_pkg::unit_cmd_t cmd_i,
  input  wire logic [63:0]       x_i,
  input  wire logic [63:0]       y_i,
  output logic                   busy_o,
  output logic [63:0]            p_o,  // product low or quotient
  output logic [63:0]            r_o   // remainder
);
  logic        busy_q, busy_d, mul_q, mul_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic [64:0] trial;

  always_comb begin
    busy_d = busy_q; mul_d = mul_q; cnt_d = cnt_q;
    acc_d = acc_q; x_d = x_q; y_d = y_q;
    trial = '0;
    if (cmd_i.start) begin
      busy_d = 1'b1; mul_d = cmd_i.is_mul; cnt_d = 7'd0;
      acc_d = '0; x_d = x_i; y_d = y_i;
    end else if (busy_q) begin
      if (mul_q) begin
        if (x_q[0]) acc_d = acc_q + y_q;
        x_d = {1'b0, x_q[63:1]};
        y_d = {y_q[62:0], 1'b0};
      end else begin
        // acc is remainder, x shifts into quotient
        trial = {acc_q, x_q[63]} - {1'b0, y_q};
        if (!trial[64]) begin
          acc_d = trial[63:0];
          x_d = {x_q[62:0], 1'b1};
        end else begin
          acc_d = {acc_q[62:0], x_q[63]};
          x_d = {x_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; mul_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; mul_q <= mul_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; x_q <= x_d; y_q <= y_d;
  end

  assign busy_o = busy_q;
  assign p_o = mul_q ? acc_q : x_q;
  assign r_o = acc_q;
endmodule
`default_nettype wire

/* test/exact_rational_alu_tb.sv */
// Testbench for the exact rational ALU: directed and random operand streams.
// Depends on era_pkg and exact_rational_alu; checks every result beat in order.
`default_nettype none
module exact_rational_alu_tb;

  // field order matches the result tdata, highest bits first
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] den;
    logic [63:0] num;
  } rat_res_t;

  localparam int CYCLE_LIMIT = 20000000;

  // Expected-result store and comparison.
  class rational_scoreboard;
    rat_res_t pending_q[$];
    int       mismatches;
    int       checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    function void note_input(rat_res_t r);
      pending_q.push_back(r);
    endfunction

    function void check_result(rat_res_t got);
      rat_res_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.num !== want.num || got.den !== want.den || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp num=%h den=%h st=%0d, got num=%h den=%h st=%0d",
                   checked, want.num, want.den, want.status, got.num, got.den, got.status);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;

  rational_scoreboard sb;
  int  cycles = 0;
  int  sent = 0;
  int  op_hits [4];

  exact_rational_alu u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Split a 32-bit two's complement numerator into sign and magnitude.
  function automatic void to_sign_mag(logic [31:0] x, output bit neg, output logic [63:0] mag);
    neg = x[31];
    mag = neg ? {32'd0, (~x) + 32'd1} : {32'd0, x};
    if (neg && mag == 0) mag = 64'h8000_0000;
  endfunction

  function automatic logic [63:0] signed_of(bit neg, logic [63:0] mag);
    return neg ? (~mag) + 64'd1 : mag;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Signed-magnitude sum, range check, then reduction by gcd.
  function automatic rat_res_t sum_reduced(bit n1, logic [63:0] m1, bit n2, logic [63:0] m2,
                                           logic [63:0] den);
    rat_res_t    r;
    bit          neg;
    logic [64:0] wide;
    logic [63:0] mag, g;
    r = '0;
    if (n1 == n2) begin
      wide = {1'b0, m1} + {1'b0, m2};
      if (wide[64]) begin
        r.status = era_pkg::ST_OVF;
        return r;
      end
      mag = wide[63:0];
      neg = n1;
    end else if (m1 >= m2) begin
      mag = m1 - m2;
      neg = n1;
    end else begin
      mag = m2 - m1;
      neg = n2;
    end
    if (mag == 0) neg = 1'b0;
    if ((neg && mag > 64'h8000_0000_0000_0000) || (!neg && mag[63])) begin
      r.status = era_pkg::ST_OVF;
      return r;
    end
    g = gcd64(mag, den);
    if (g > 1) begin
      mag = mag / g;
      den = den / g;
    end
    r.num    = signed_of(neg, mag);
    r.den    = den;
    r.status = era_pkg::ST_OK;
    return r;
  endfunction

  function automatic rat_res_t predict_rational(era_pkg::op_e op, logic [31:0] an_raw,
                                                logic [31:0] ad32,
                                                logic [31:0] bn_raw, logic [31:0] bd32);
    rat_res_t    r;
    bit          an, bn;
    logic [63:0] am, bm, ad, bd;
    ad = {32'd0, ad32};
    bd = {32'd0, bd32};
    to_sign_mag(an_raw, an, am);
    to_sign_mag(bn_raw, bn, bm);
    r.num    = signed_of(an, am);
    r.den    = ad;
    r.status = era_pkg::ST_OK;
    case (op)
      era_pkg::OP_ADD, era_pkg::OP_SUB: begin
        if (op == era_pkg::OP_ADD && am == 0) begin
          r.num = signed_of(bn, bm);
          r.den = bd;
        end else if (bm != 0) begin
          if (op == era_pkg::OP_SUB) bn = !bn;
          if (ad != bd) r = sum_reduced(an, am * bd, bn, bm * ad, ad * bd);
          else          r = sum_reduced(an, am, bn, bm, ad);
        end
      end
      era_pkg::OP_MUL: begin
        if (am != 0) begin
          if (bm == 0) r.num = '0;
          else begin
            r.num = signed_of(an != bn, am * bm);
            r.den = ad * bd;
          end
        end
      end
      default: begin
        if (am != 0) begin
          if (bm == 0) begin
            r.num    = '0;
            r.den    = '0;
            r.status = era_pkg::ST_DIV0;
          end else begin
            r.num = signed_of(an != bn, am * bd);
            r.den = ad * bm;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Drive one operand beat and wait until the block takes it.
  task automatic send_operands(era_pkg::op_e op, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {bd, bn, ad, an};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(predict_rational(op, an, ad, bn, bd));
    op_hits[op]++;
    sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Numerator mostly small, sometimes extreme or fully random.
  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'd0;
      3, 4:    return $urandom();
      default: return $signed($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  function automatic logic [31:0] pick_den();
    case ($urandom_range(0, 9))
      0:       return 32'hffff_ffff;
      1:       return 32'd1;
      2, 3:    return $urandom() | 32'd1;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  // Receiver: stalls follow an LFSR mask, with a free-running stretch.
  logic [15:0] stall_mask = 16'b1011_0010_1100_0110;
  always @(negedge clk_i) begin
    if (cycles % 4000 < 1500) m_axis_tready <= 1'b1;
    else begin
      m_axis_tready <= stall_mask[0];
      stall_mask    <= {stall_mask[0] ^ stall_mask[5], stall_mask[15:1]};
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[129:0]);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[exact_rational_alu] ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0]  an, ad, bn, bd;
    int           burst;
    era_pkg::op_e op;
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes and zero-operand cases for each operation.
    send_operands(era_pkg::OP_ADD, 32'd0, 32'd7, 32'd3, 32'd5);
    send_operands(era_pkg::OP_ADD, 32'd3, 32'd4, 32'd0, 32'd9);
    send_operands(era_pkg::OP_SUB, 32'd6, 32'd4, 32'd0, 32'd9);
    send_operands(era_pkg::OP_SUB, 32'd0, 32'd4, 32'd6, 32'd9);
    send_operands(era_pkg::OP_SUB, 32'd5, 32'd3, 32'd5, 32'd3);
    send_operands(era_pkg::OP_ADD, 32'd1, 32'd6, 32'd1, 32'd6);
    send_operands(era_pkg::OP_ADD, -32'sd1, 32'd2, 32'd1, 32'd3);
    send_operands(era_pkg::OP_MUL, 32'd0, 32'd5, 32'd7, 32'd3);
    send_operands(era_pkg::OP_MUL, 32'd4, 32'd5, 32'd0, 32'd3);
    send_operands(era_pkg::OP_MUL, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                  32'hffff_ffff);
    send_operands(era_pkg::OP_MUL, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1);
    send_operands(era_pkg::OP_DIV, 32'd0, 32'd5, 32'd0, 32'd3);
    send_operands(era_pkg::OP_DIV, 32'd3, 32'd5, 32'd0, 32'd3);
    send_operands(era_pkg::OP_DIV, 32'd3, 32'd5, -32'sd4, 32'd7);
    send_operands(era_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                  32'hffff_ffff);
    send_operands(era_pkg::OP_ADD, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                  32'hffff_fffe);
    send_operands(era_pkg::OP_SUB, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000,
                  32'hffff_fffe);
    send_operands(era_pkg::OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_operands(era_pkg::OP_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
    send_operands(era_pkg::OP_ADD, 32'hffff_ffff, 32'd1, 32'd1, 32'd1);

    // Random bursts with random gaps; some back to back.
    while (sent < 720) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        op = era_pkg::op_e'($urandom_range(0, 3));
        an = pick_num();
        bn = pick_num();
        ad = pick_den();
        bd = ($urandom_range(0, 3) == 0) ? ad : pick_den();
        send_operands(op, an, ad, bn, bd);
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 40));
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d operand beats: add %0d, sub %0d, mul %0d, div %0d",
             sent, op_hits[era_pkg::OP_ADD], op_hits[era_pkg::OP_SUB],
             op_hits[era_pkg::OP_MUL], op_hits[era_pkg::OP_DIV]);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("[exact_rational_alu] OK");
    else
      $display("[exact_rational_alu] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
